// File: rtl/swls_pkg.sv
package swls_pkg;

  localparam int MAX_LEN   = 64;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 8;
  localparam int SCORE_W   = 14;
  localparam int CALC_W    = SCORE_W + 2;
  localparam int SCORE_MAX = (1 << SCORE_W) - 1;
  localparam int APPROX_SCORE = 2;

  localparam logic [1:0] REG_MATCH_SCORE   = 2'd0;
  localparam logic [1:0] REG_GAP_PENALTY   = 2'd1;
  localparam logic [1:0] REG_APPROX_ENABLE = 2'd2;

  localparam logic [2:0] GRP_NONE  = 3'd0;
  localparam logic [2:0] GRP_DT    = 3'd1;
  localparam logic [2:0] GRP_GJ    = 3'd2;
  localparam logic [2:0] GRP_LR    = 3'd3;
  localparam logic [2:0] GRP_MN    = 3'd4;
  localparam logic [2:0] GRP_BPV   = 3'd5;
  localparam logic [2:0] GRP_VOWEL = 3'd6;
  localparam logic [2:0] GRP_PUNCT = 3'd7;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic end_pass;
    logic close;
    logic emit;
  } swls_cmd_t;

  typedef struct packed {
    logic rd_done;
    logic pipe_empty;
  } swls_sts_t;

  function automatic logic [2:0] char_group(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    logic [2:0]        grp;
    lc = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      lc = c + 8'h20;
    end
    case (lc) inside
      8'h64, 8'h74:                      grp = GRP_DT;
      8'h67, 8'h6a:                      grp = GRP_GJ;
      8'h6c, 8'h72:                      grp = GRP_LR;
      8'h6d, 8'h6e:                      grp = GRP_MN;
      8'h62, 8'h70, 8'h76:               grp = GRP_BPV;
      8'h61, 8'h65, 8'h69, 8'h6f, 8'h75: grp = GRP_VOWEL;
      8'h2c, 8'h2e:                      grp = GRP_PUNCT;
      default:                           grp = GRP_NONE;
    endcase
    return grp;
  endfunction

endpackage

// File: rtl/smith_waterman_local_score.sv
// Smith-Waterman local alignment score, linear gap cost.
// Input channel (in_valid/in_stall): in_op = 0 loads one first-string
// character, in_op = 1 streams one second-string character; in_last ends
// the current string. At most 64 first-string characters are kept, the
// rest are dropped and reported through out_truncated.
// A load transaction leaves the input channel free. A streamed transaction
// walks the stored row one cell per cycle through the character and score
// memories, and in_stall stays high until the pass is done. A streamed
// character marked last then passes through a final state that waits for the
// output register to be free, moves the result into it and raises out_valid.
// Output channel (out_valid/out_stall): one transaction with out_best_score
// after each streamed character marked last. The result sits in an output
// register; a stalled result holds while the block takes further items, and
// only a new result waits for the register to drain.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 match score,
// 1 gap penalty, 2 approximate enable; cfg_ready is always high. Write only
// while idle.
// Reset (rst_n, synchronous): match 5, gap 1, approximate off, empty first
// string, no result pending.
module smith_waterman_local_score (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [swls_pkg::CHAR_W-1:0]  in_char_in,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swls_pkg::SCORE_W-1:0] out_best_score,
  output logic                         out_truncated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [swls_pkg::CFG_W-1:0]   cfg_data
);
  import swls_pkg::*;

  swls_cmd_t cmd;
  swls_sts_t sts;

  assign cfg_ready = 1'b1;

  swls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  swls_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_char_in     (in_char_in),
    .in_last        (in_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_best_score (out_best_score),
    .out_truncated  (out_truncated)
  );

  a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_op && !in_stall |=> in_stall)
    else $error("streamed transaction did not occupy the block");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> sts.pipe_empty)
    else $error("cell pipeline busy while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result raised without emit");

endmodule

// File: rtl/swls_ctrl.sv
module swls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                in_last,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  output swls_pkg::swls_cmd_t cmd,
  input  swls_pkg::swls_sts_t sts
);
  import swls_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       accept;
  logic       pass_done;
  logic       slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign pass_done = sts.rd_done && sts.pipe_empty;
  assign slot_free = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    cmd          = '0;
    cmd.load     = accept && !in_op;
    cmd.start    = accept && in_op;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          last_nxt  = in_last;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = !sts.rd_done;
        if (pass_done) begin
          cmd.end_pass = 1'b1;
          cmd.close    = last_r;
          state_nxt    = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_vld_nxt = 1'b1;
    end else begin
      out_vld_nxt = out_vld_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      last_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      last_r    <= last_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: rtl/swls_dp.sv
module swls_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [1:0]                           cfg_index,
  input  logic [swls_pkg::CFG_W-1:0]           cfg_data,
  input  logic [swls_pkg::CHAR_W-1:0]          in_char_in,
  input  logic                                 in_last,
  input  swls_pkg::swls_cmd_t                  cmd,
  output swls_pkg::swls_sts_t                  sts,
  output logic [swls_pkg::SCORE_W-1:0]         out_best_score,
  output logic                                 out_truncated
);
  import swls_pkg::*;

  logic [CFG_W-1:0]   match_r;
  logic [CFG_W-1:0]   gap_r;
  logic               approx_r;

  logic [CHAR_W-1:0]  chars_mem [MAX_LEN];
  logic [SCORE_W-1:0] row_mem   [MAX_LEN];

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic               load_open_r, load_open_nxt;
  logic               stream_open_r, stream_open_nxt;
  logic               fresh_r, fresh_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic               cell_vld_r;
  logic [ADDR_W-1:0]  cell_idx_r;
  logic [LEN_W-1:0]   rd_idx_r;
  logic [SCORE_W-1:0] up_r;
  logic [SCORE_W-1:0] diag_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [CHAR_W-1:0]  chars_q;
  logic [SCORE_W-1:0] row_q;
  logic [SCORE_W-1:0] out_best_r;
  logic               out_trunc_r;

  logic [LEN_W-1:0]   base_len;
  logic               full;
  logic [SCORE_W-1:0] left;
  logic [2:0]         grp_a;
  logic [2:0]         grp_b;
  logic signed [CALC_W-1:0] sim;
  logic signed [CALC_W-1:0] gap_s;
  logic signed [CALC_W-1:0] cand_d, cand_u, cand_l, cand;
  logic [SCORE_W-1:0] cell_score;

  // Load side
  assign base_len = load_open_r ? len_r : '0;
  assign full     = (base_len == LEN_W'(MAX_LEN));

  // Cell arithmetic
  assign left  = fresh_r ? '0 : row_q;
  assign grp_a = char_group(chars_q);
  assign grp_b = char_group(ch_r);
  assign gap_s = signed'(CALC_W'(gap_r));

  always_comb begin
    if (chars_q == ch_r) begin
      sim = signed'(CALC_W'(match_r));
    end else if (approx_r && grp_a != GRP_NONE && grp_a == grp_b) begin
      sim = CALC_W'(APPROX_SCORE);
    end else begin
      sim = -gap_s;
    end
    cand_d = signed'(CALC_W'(diag_r)) + sim;
    cand_u = signed'(CALC_W'(up_r)) - gap_s;
    cand_l = signed'(CALC_W'(left)) - gap_s;
    cand   = cand_d;
    if (cand_u > cand) begin
      cand = cand_u;
    end
    if (cand_l > cand) begin
      cand = cand_l;
    end
    if (cand < 0) begin
      cell_score = '0;
    end else if (cand > signed'(CALC_W'(SCORE_MAX))) begin
      cell_score = SCORE_W'(SCORE_MAX);
    end else begin
      cell_score = cand[SCORE_W-1:0];
    end
  end

  always_comb begin
    len_nxt         = len_r;
    ovf_nxt         = ovf_r;
    load_open_nxt   = load_open_r;
    stream_open_nxt = stream_open_r;
    fresh_nxt       = fresh_r;
    best_nxt        = best_r;
    if (cmd.load) begin
      stream_open_nxt = 1'b0;
      load_open_nxt   = !in_last;
      ovf_nxt         = (load_open_r && ovf_r) || full;
      len_nxt         = full ? base_len : base_len + LEN_W'(1);
    end
    if (cmd.start) begin
      load_open_nxt   = 1'b0;
      stream_open_nxt = 1'b1;
      if (!stream_open_r) begin
        fresh_nxt = 1'b1;
        best_nxt  = '0;
      end
    end
    if (cell_vld_r && cell_score > best_r) begin
      best_nxt = cell_score;
    end
    if (cmd.end_pass) begin
      fresh_nxt = 1'b0;
    end
    if (cmd.close) begin
      stream_open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r       <= CFG_W'(5);
      gap_r         <= CFG_W'(1);
      approx_r      <= 1'b0;
      len_r         <= '0;
      ovf_r         <= 1'b0;
      load_open_r   <= 1'b0;
      stream_open_r <= 1'b0;
      fresh_r       <= 1'b0;
      best_r        <= '0;
      cell_vld_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MATCH_SCORE:   match_r  <= cfg_data;
          REG_GAP_PENALTY:   gap_r    <= cfg_data;
          REG_APPROX_ENABLE: approx_r <= cfg_data[0];
          default: ;
        endcase
      end
      len_r         <= len_nxt;
      ovf_r         <= ovf_nxt;
      load_open_r   <= load_open_nxt;
      stream_open_r <= stream_open_nxt;
      fresh_r       <= fresh_nxt;
      best_r        <= best_nxt;
      cell_vld_r    <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      chars_mem[base_len[ADDR_W-1:0]] <= in_char_in;
    end
    if (cmd.issue) begin
      chars_q <= chars_mem[rd_idx_r[ADDR_W-1:0]];
      row_q   <= row_mem[rd_idx_r[ADDR_W-1:0]];
    end
    if (cell_vld_r) begin
      row_mem[cell_idx_r] <= cell_score;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ch_r     <= in_char_in;
      rd_idx_r <= '0;
      up_r     <= '0;
      diag_r   <= '0;
    end else begin
      if (cmd.issue) begin
        rd_idx_r   <= rd_idx_r + LEN_W'(1);
        cell_idx_r <= rd_idx_r[ADDR_W-1:0];
      end
      if (cell_vld_r) begin
        up_r   <= cell_score;
        diag_r <= left;
      end
    end
    if (cmd.emit) begin
      out_best_r  <= best_r;
      out_trunc_r <= ovf_r;
    end
  end

  assign sts.rd_done    = (rd_idx_r == len_r);
  assign sts.pipe_empty = !cell_vld_r;
  assign out_best_score = out_best_r;
  assign out_truncated  = out_trunc_r;

endmodule
